// File: rtl/phwm_pkg.sv
// Shared types, constants and character compare functions for the phonetic word matcher.
package phwm_pkg;

    // Longest word that can still match, and the byte counter width
    localparam int MAX_WORD    = 16;
    localparam int OFFSET_BITS = 32;

    // Character slots carried by the target and result fields
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    // Word length counter saturates one past the longest word
    localparam int POS_W     = $clog2(NUM_SLOTS + 2);
    localparam int STORE_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    localparam int TLEN_W    = 5;
    localparam int CHARS_W   = 64;
    localparam int OFS_OUT_W = 32;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    // Register indexes, one register per 8-byte slot
    localparam logic [1:0] REG_TARGET_LO  = 2'd0;
    localparam logic [1:0] REG_TARGET_HI  = 2'd1;
    localparam logic [1:0] REG_TARGET_LEN = 2'd2;

    // Sound class codes
    localparam logic [3:0] CLS_NONE = 4'd0;
    localparam logic [3:0] CLS_VW   = 4'd1;
    localparam logic [3:0] CLS_BFP  = 4'd2;
    localparam logic [3:0] CLS_GJ   = 4'd3;
    localparam logic [3:0] CLS_CKQ  = 4'd4;
    localparam logic [3:0] CLS_SZ   = 4'd5;
    localparam logic [3:0] CLS_DT   = 4'd6;
    localparam logic [3:0] CLS_OU   = 4'd7;
    localparam logic [3:0] CLS_IY   = 4'd8;

    typedef struct packed {
        logic [CHARS_W-1:0] target_lo;
        logic [CHARS_W-1:0] target_hi;
        logic [TLEN_W-1:0]  target_len;
    } t_cfg;

    typedef struct packed {
        logic                 found;
        logic [OFS_OUT_W-1:0] offset;
        logic [CHARS_W-1:0]   bytes_lo;
        logic [CHARS_W-1:0]   bytes_hi;
    } t_result;

    // Space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // Fold upper-case letters to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) ? c + 8'd32 : c;
    endfunction

    function automatic logic [3:0] sound_class(input logic [7:0] c);
        logic [3:0] cls;
        unique case (c)
            "v", "w":      cls = CLS_VW;
            "b", "f", "p": cls = CLS_BFP;
            "g", "j":      cls = CLS_GJ;
            "c", "k", "q": cls = CLS_CKQ;
            "s", "z":      cls = CLS_SZ;
            "d", "t":      cls = CLS_DT;
            "o", "u":      cls = CLS_OU;
            "i", "y":      cls = CLS_IY;
            default:       cls = CLS_NONE;
        endcase
        return cls;
    endfunction

    // Equal ignoring case, or both letters of one sound class
    function automatic logic chars_match(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] fa;
        logic [7:0] fb;
        logic [3:0] ca;
        fa = fold_case(a);
        fb = fold_case(b);
        ca = sound_class(fa);
        return (fa == fb) || ((ca != CLS_NONE) && (ca == sound_class(fb)));
    endfunction

endpackage

// File: rtl/phwm_cfg.sv
// Configuration register file with APB-style access for the target word.
module phwm_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [phwm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [phwm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [phwm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output phwm_pkg::t_cfg                   o_cfg
);
    import phwm_pkg::*;

    logic [CHARS_W-1:0] r_target_lo;
    logic [CHARS_W-1:0] r_target_hi;
    logic [TLEN_W-1:0]  r_target_len;
    logic [1:0]         reg_idx;
    logic               wr_en;

    // Registers sit on 8-byte boundaries
    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_lo  <= '0;
            r_target_hi  <= '0;
            r_target_len <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TARGET_LO:  r_target_lo  <= pwdata[CHARS_W-1:0];
                REG_TARGET_HI:  r_target_hi  <= pwdata[CHARS_W-1:0];
                REG_TARGET_LEN: r_target_len <= pwdata[TLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_TARGET_LO:  prdata = APB_DATA_W'(r_target_lo);
            REG_TARGET_HI:  prdata = APB_DATA_W'(r_target_hi);
            REG_TARGET_LEN: prdata = APB_DATA_W'(r_target_len);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.target_lo  = r_target_lo;
    assign o_cfg.target_hi  = r_target_hi;
    assign o_cfg.target_len = r_target_len;

endmodule

// File: rtl/phwm_scan.sv
// Input register and one-pass word tracking, compare and result build for each text byte.
module phwm_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_text_byte,
    input  logic              i_end_of_text,
    input  phwm_pkg::t_cfg    i_cfg,
    input  logic              i_res_take,
    output logic              o_res_valid,
    output phwm_pkg::t_result o_res
);
    import phwm_pkg::*;

    // Input stage
    logic                   r_s1_valid;
    logic [7:0]             r_s1_byte;
    logic                   r_s1_last;

    // Text state
    logic                   r_inside;
    logic [POS_W-1:0]       r_pos;
    logic                   r_mismatch;
    logic [OFFSET_BITS-1:0] r_count;
    logic [OFFSET_BITS-1:0] r_start;
    logic                   r_reported;
    logic [7:0]             r_store [MAX_WORD];

    logic                   live;
    logic                   s1_space;
    logic                   starting;
    logic [POS_W-1:0]       base_pos;
    logic [POS_W-1:0]       pos_after;
    logic [POS_W-1:0]       tlen;
    logic [OFFSET_BITS-1:0] base_start;
    logic                   mismatch_after;
    logic                   write_ok;
    logic [7:0]             tgt_char;
    logic [2*CHARS_W-1:0]   tgt_all;
    logic                   ends_word;
    logic                   hit;
    logic                   has_res;
    logic                   advance;
    logic [7:0]             res_byte [NUM_SLOTS];

    // Work out the byte against the word state
    always_comb begin
        live       = !r_reported;
        s1_space   = is_space(r_s1_byte);
        starting   = !s1_space && !r_inside;
        base_pos   = starting ? '0 : r_pos;
        base_start = starting ? r_count : r_start;
        tlen       = POS_W'(i_cfg.target_len);
        tgt_all    = {i_cfg.target_hi, i_cfg.target_lo};
        tgt_char   = tgt_all[{base_pos[SLOT_W-1:0], 3'b000} +: 8];
        write_ok   = !s1_space && (base_pos < POS_W'(MAX_WORD));

        mismatch_after = (starting ? 1'b0 : r_mismatch) ||
                         (write_ok && (base_pos < tlen) && !chars_match(tgt_char, r_s1_byte));

        pos_after = (!s1_space && (base_pos <= POS_W'(MAX_WORD))) ?
                    base_pos + POS_W'(1) : base_pos;

        ends_word = s1_space ? r_inside : r_s1_last;
        hit       = live && ends_word && !mismatch_after && (pos_after == tlen) &&
                    (tlen != '0) && (tlen <= POS_W'(MAX_WORD));
        has_res   = hit || (r_s1_last && !r_reported);
        advance   = r_s1_valid && (!has_res || i_res_take);
    end

    assign o_in_ready  = !r_s1_valid || advance;
    assign o_res_valid = advance && has_res;

    // Gather the word bytes, current byte included, zero past the word end
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
        if (g < MAX_WORD) begin : g_stored
            always_comb begin
                if (!hit || (POS_W'(g) >= pos_after)) begin
                    res_byte[g] = 8'd0;
                end else if (write_ok && (base_pos == POS_W'(g))) begin
                    res_byte[g] = r_s1_byte;
                end else begin
                    res_byte[g] = r_store[g];
                end
            end
        end else begin : g_unused
            assign res_byte[g] = 8'd0;
        end
    end

    always_comb begin
        o_res.found  = hit;
        o_res.offset = hit ? OFS_OUT_W'(base_start) : '0;
        for (int i = 0; i < NUM_SLOTS / 2; i++) begin
            o_res.bytes_lo[i*8 +: 8] = res_byte[i];
            o_res.bytes_hi[i*8 +: 8] = res_byte[i + NUM_SLOTS / 2];
        end
    end

    // Hold the input beat until it is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_byte <= i_text_byte;
            r_s1_last <= i_end_of_text;
        end
    end

    // Advance the text state; end of text starts a fresh text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside   <= 1'b0;
            r_pos      <= '0;
            r_mismatch <= 1'b0;
            r_count    <= '0;
            r_start    <= '0;
            r_reported <= 1'b0;
        end else if (advance) begin
            if (r_s1_last) begin
                r_inside   <= 1'b0;
                r_pos      <= '0;
                r_mismatch <= 1'b0;
                r_count    <= '0;
                r_start    <= '0;
                r_reported <= 1'b0;
            end else if (live) begin
                r_inside   <= !s1_space;
                r_pos      <= pos_after;
                r_mismatch <= mismatch_after;
                r_count    <= r_count + OFFSET_BITS'(1);
                r_start    <= base_start;
                r_reported <= hit;
            end
        end
    end

    // Store word characters
    always_ff @(posedge i_clk) begin
        if (advance && live && write_ok) begin
            r_store[base_pos[STORE_W-1:0]] <= r_s1_byte;
        end
    end

`ifndef SYNTH
    a_res_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_res_take)
        else $error("result produced while the output stage is full");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s1_last) |=> (!r_reported && (r_count == '0) && !r_inside))
        else $error("text state not cleared after end of text");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_WORD + 1))
        else $error("word length counter past saturation");
`endif

endmodule

// File: rtl/phonetic_word_matcher.sv
// Top level of the phonetic word matcher: configuration, scan stage and result register.
//
// Usage:
//   Text enters one byte per beat on the input channel (i_in_valid / o_in_ready),
//   with i_end_of_text set on the final byte. Results leave on the output channel
//   (o_out_valid / i_out_ready): one beat with found set for the first word that
//   matches the target, or one beat with found clear and zero payload when the
//   text ends without a match. Bytes after a match give no beat; end of text then
//   starts a new text.
//   The target characters and length must be written through the APB port while the
//   block is idle; the block itself does not enforce this. pready is always high.
//   The byte is captured in the input register when it is accepted, and its
//   result is loaded from there into the result register, which raises
//   o_out_valid, once the result register can take it.
//   Throughput: one byte per cycle unless a byte with a result waits for a stalled
//   receiver; the word state is updated between the input and result registers.
//   Reset clears the configuration, the text state and both valid flags.
//   When the receiver stalls, a waiting result holds; bytes that give no result
//   keep flowing, and a byte that gives a result waits in the input register.
module phonetic_word_matcher (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [phwm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [phwm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [phwm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_text_byte,
    input  logic                             i_end_of_text,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic [phwm_pkg::OFS_OUT_W-1:0]   o_match_offset,
    output logic [phwm_pkg::CHARS_W-1:0]     o_word_bytes_low,
    output logic [phwm_pkg::CHARS_W-1:0]     o_word_bytes_high
);
    import phwm_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result r_out;
    logic    res_valid;
    logic    res_take;
    logic    r_out_valid;

    phwm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    phwm_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_cfg         (cfg),
        .i_res_take    (res_take),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // Result register frees up when empty or when its beat is taken
    assign res_take = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_found           = r_out.found;
    assign o_match_offset    = r_out.offset;
    assign o_word_bytes_low  = r_out.bytes_lo;
    assign o_word_bytes_high = r_out.bytes_hi;

`ifndef SYNTH
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
            ((o_match_offset == '0) && (o_word_bytes_low == '0) && (o_word_bytes_high == '0)))
        else $error("not-found beat carries a nonzero payload");

    a_found_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (cfg.target_len != '0))
        else $error("match reported with zero target length");
`endif

endmodule

// File: sim/phonetic_word_matcher_checker.sv
// Scoreboard for the phonetic word matcher: follows the text scan and checks every result beat.
`timescale 1ns / 100ps
module phonetic_word_matcher_checker (
    input  logic                            i_clk,
    input  phwm_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_text_byte,
    input  logic                            i_end_of_text,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_found,
    input  logic [phwm_pkg::OFS_OUT_W-1:0]  i_match_offset,
    input  logic [phwm_pkg::CHARS_W-1:0]    i_word_bytes_low,
    input  logic [phwm_pkg::CHARS_W-1:0]    i_word_bytes_high,
    output int                              o_results_due,
    output int                              o_fail_count
);
    import phwm_pkg::*;

    typedef enum logic [3:0] {
        GRP_NONE, GRP_VW, GRP_BFP, GRP_GJ, GRP_CKQ, GRP_SZ, GRP_DT, GRP_OU, GRP_IY
    } t_sound_group;

    // Scan state of the current text
    logic        in_word;
    logic [4:0]  word_len;      // saturates at MAX_WORD + 1
    logic        word_bad;
    logic [31:0] text_pos;
    logic [31:0] word_start;
    logic [7:0]  word_buf [MAX_WORD];
    logic        matched;

    t_result     results_due [$];
    int          due_count;
    int          fail_total;

    assign o_results_due = due_count;
    assign o_fail_count  = fail_total;

    function automatic logic is_blank(input logic [7:0] ch);
        return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0d));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] ch);
        return ((ch >= "A") && (ch <= "Z")) ? ch + 8'd32 : ch;
    endfunction

    function automatic t_sound_group group_of(input logic [7:0] ch);
        case (ch)
            "v", "w":      return GRP_VW;
            "b", "f", "p": return GRP_BFP;
            "g", "j":      return GRP_GJ;
            "c", "k", "q": return GRP_CKQ;
            "s", "z":      return GRP_SZ;
            "d", "t":      return GRP_DT;
            "o", "u":      return GRP_OU;
            "i", "y":      return GRP_IY;
            default:       return GRP_NONE;
        endcase
    endfunction

    function automatic logic sounds_alike(input logic [7:0] a, input logic [7:0] b);
        logic [7:0]   la;
        logic [7:0]   lb;
        t_sound_group ga;
        la = to_lower(a);
        lb = to_lower(b);
        ga = group_of(la);
        return (la == lb) || ((ga != GRP_NONE) && (ga == group_of(lb)));
    endfunction

    // Drop all per-text state so the next byte opens a new text
    function automatic void start_new_text();
        in_word    = 1'b0;
        word_len   = '0;
        word_bad   = 1'b0;
        text_pos   = '0;
        word_start = '0;
        matched    = 1'b0;
    endfunction

    // Advance the scan by one byte; returns 1 when the byte yields a result
    function automatic logic scan_byte(input logic [7:0] ch, input logic last,
                                       output t_result res);
        logic       closes;
        logic       hit;
        logic       was_matched;
        logic [7:0] want;
        closes = 1'b0;
        hit    = 1'b0;
        res    = '0;
        if (!matched) begin
            if (is_blank(ch)) begin
                closes = in_word;
            end else begin
                if (!in_word) begin
                    in_word    = 1'b1;
                    word_len   = '0;
                    word_bad   = 1'b0;
                    word_start = text_pos;
                end
                if (word_len < MAX_WORD) begin
                    word_buf[word_len[3:0]] = ch;
                    want = word_len[3] ? i_cfg.target_hi[8*word_len[2:0] +: 8]
                                       : i_cfg.target_lo[8*word_len[2:0] +: 8];
                    if ((word_len < i_cfg.target_len) && !sounds_alike(want, ch))
                        word_bad = 1'b1;
                end
                if (word_len <= MAX_WORD)
                    word_len = word_len + 5'd1;
                closes = last;
            end
            if (closes) begin
                in_word = 1'b0;
                hit = !word_bad && (word_len <= MAX_WORD) && (i_cfg.target_len != 0) &&
                      (i_cfg.target_len <= MAX_WORD) && (word_len == i_cfg.target_len);
            end
            text_pos = text_pos + 32'd1;
        end

        if (hit) begin
            res.found  = 1'b1;
            res.offset = word_start;
            for (int k = 0; k < MAX_WORD; k++) begin
                if (k < word_len) begin
                    if (k < 8)
                        res.bytes_lo[8*k +: 8] = word_buf[k];
                    else
                        res.bytes_hi[8*(k-8) +: 8] = word_buf[k];
                end
            end
            matched = 1'b1;
            if (last)
                start_new_text();
            return 1'b1;
        end

        // End of text: not found unless this text already reported a match
        if (last) begin
            was_matched = matched;
            start_new_text();
            return !was_matched;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    initial begin
        start_new_text();
        for (int k = 0; k < MAX_WORD; k++)
            word_buf[k] = '0;
        due_count  = 0;
        fail_total = 0;
    end

    // Compare each result beat with the oldest prediction, then scan the input beat
    always @(posedge i_clk) begin : track_beats
        t_result want;
        t_result next_res;
        if (i_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                fail_total++;
                $display("%0t: expected no result, got found=%b offset=%h low=%h high=%h",
                         $time, i_found, i_match_offset, i_word_bytes_low, i_word_bytes_high);
            end else begin
                want = results_due.pop_front();
                check_field("found", want.found, i_found);
                check_field("match_offset", want.offset, i_match_offset);
                check_field("word_bytes_low", want.bytes_lo, i_word_bytes_low);
                check_field("word_bytes_high", want.bytes_hi, i_word_bytes_high);
            end
        end
        if (i_in_valid && i_in_ready) begin
            if (scan_byte(i_text_byte, i_end_of_text, next_res))
                results_due.push_back(next_res);
        end
        due_count = results_due.size();
    end

endmodule

// File: sim/phonetic_word_matcher_tb.sv
// Testbench top for the phonetic word matcher: clock, reset, text stimulus and verdict.
`timescale 1ns / 100ps
module phonetic_word_matcher_tb;
    import phwm_pkg::*;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_MOSTLY
    } t_ready_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_beat;

    localparam int REG_STRIDE      = 8;
    localparam int RESET_CYCLES    = 7;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_LIMIT      = 5000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int NUM_PHASES      = 9;
    localparam int BEATS_PER_PHASE = 140;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [7:0]             i_text_byte;
    logic                   i_end_of_text;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_found;
    logic [OFS_OUT_W-1:0]   o_match_offset;
    logic [CHARS_W-1:0]     o_word_bytes_low;
    logic [CHARS_W-1:0]     o_word_bytes_high;

    t_cfg                   target_cfg;
    int                     results_due;
    int                     fail_count;

    logic [7:0]             text_chars [$];
    t_text_beat             text_beats [$];
    int                     burst_left;
    logic                   hold_off_req;
    logic                   hold_off_done;

    phonetic_word_matcher DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_text_byte       (i_text_byte),
        .i_end_of_text     (i_end_of_text),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_found           (o_found),
        .o_match_offset    (o_match_offset),
        .o_word_bytes_low  (o_word_bytes_low),
        .o_word_bytes_high (o_word_bytes_high)
    );

    phonetic_word_matcher_checker u_checker (
        .i_clk             (i_clk),
        .i_cfg             (target_cfg),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_text_byte       (i_text_byte),
        .i_end_of_text     (i_end_of_text),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_found           (o_found),
        .i_match_offset    (o_match_offset),
        .i_word_bytes_low  (o_word_bytes_low),
        .i_word_bytes_high (o_word_bytes_high),
        .o_results_due     (results_due),
        .o_fail_count      (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic is_blank_byte(input logic [7:0] ch);
        return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0d));
    endfunction

    function automatic logic is_letter(input logic [7:0] ch);
        return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + 8'($urandom_range(0, 25));
    endfunction

    // Any byte that can sit inside a word
    function automatic logic [7:0] random_word_byte();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (is_blank_byte(ch))
            ch = ch + 8'h40;
        return ch;
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0a;
            3:       return 8'h0b;
            4:       return 8'h0c;
            default: return 8'h0d;
        endcase
    endfunction

    // Another letter of the same sound group, keeping the case
    function automatic logic [7:0] sound_sibling(input logic [7:0] ch);
        logic [7:0] lc;
        logic [7:0] sib;
        lc = ((ch >= "A") && (ch <= "Z")) ? ch + 8'd32 : ch;
        case (lc)
            "v": sib = "w";  "w": sib = "v";
            "b": sib = "f";  "f": sib = "p";  "p": sib = "b";
            "g": sib = "j";  "j": sib = "g";
            "c": sib = "k";  "k": sib = "q";  "q": sib = "c";
            "s": sib = "z";  "z": sib = "s";
            "d": sib = "t";  "t": sib = "d";
            "o": sib = "u";  "u": sib = "o";
            "i": sib = "y";  "y": sib = "i";
            default: return ch;
        endcase
        return (lc != ch) ? sib - 8'd32 : sib;
    endfunction

    function automatic logic [63:0] random_letter_chars();
        logic [63:0] chars;
        for (int k = 0; k < 8; k++)
            chars[8*k +: 8] = random_letter();
        return chars;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(int'(idx) * REG_STRIDE);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_TARGET_LO:  target_cfg.target_lo  = value;
            REG_TARGET_HI:  target_cfg.target_hi  = value;
            REG_TARGET_LEN: target_cfg.target_len = value[TLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_target(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [63:0] len);
        write_reg(REG_TARGET_LO, lo);
        write_reg(REG_TARGET_HI, hi);
        write_reg(REG_TARGET_LEN, len);
    endtask

    // Move the gathered characters into the beat queue, end of text on the last one
    task automatic close_text();
        t_text_beat beat;
        foreach (text_chars[k]) begin
            beat.ch   = text_chars[k];
            beat.last = (k == text_chars.size() - 1);
            text_beats.push_back(beat);
        end
        text_chars.delete();
    endtask

    task automatic add_string_text(input string s);
        for (int k = 0; k < s.len(); k++)
            text_chars.push_back(s[k]);
        close_text();
    endtask

    task automatic add_blanks();
        repeat ($urandom_range(1, 3)) text_chars.push_back(random_blank());
    endtask

    task automatic add_random_word();
        repeat ($urandom_range(1, 20)) begin
            if ($urandom_range(0, 9) < 7)
                text_chars.push_back(random_letter());
            else
                text_chars.push_back(random_word_byte());
        end
    endtask

    // Word built from the target, mostly by exact, case-swapped or same-sound characters
    task automatic add_target_word();
        int         len;
        int         pick;
        logic [7:0] want;
        logic [7:0] ch;
        len = ((target_cfg.target_len >= 1) && (target_cfg.target_len <= MAX_WORD)) ?
              int'(target_cfg.target_len) : int'($urandom_range(1, MAX_WORD));
        for (int p = 0; p < len; p++) begin
            want = (p < 8) ? target_cfg.target_lo[8*p +: 8] : target_cfg.target_hi[8*(p-8) +: 8];
            pick = $urandom_range(0, 15);
            if (pick < 9)
                ch = want;
            else if (pick < 12)
                ch = is_letter(want) ? want ^ 8'h20 : want;
            else if (pick < 15)
                ch = sound_sibling(want);
            else
                ch = random_word_byte();
            if (is_blank_byte(ch))
                ch = random_word_byte();
            text_chars.push_back(ch);
        end
        // Run some words past the length that was built from the target
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) text_chars.push_back(random_letter());
    endtask

    task automatic add_random_text();
        int n_words;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) text_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0)
                add_blanks();
            n_words = $urandom_range(1, 5);
            for (int w = 0; w < n_words; w++) begin
                if (w != 0)
                    add_blanks();
                if ($urandom_range(0, 2) == 0)
                    add_random_word();
                else
                    add_target_word();
            end
            if ($urandom_range(0, 2) == 0)
                add_blanks();
        end
        close_text();
    endtask

    // Offer queued beats in bursts with random gaps; called at a falling edge
    task automatic send_beats();
        t_text_beat beat;
        int         gap;
        while (text_beats.size() != 0) begin
            beat = text_beats.pop_front();
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    i_in_valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                         : $urandom_range(1, 24);
            end
            i_in_valid    = 1'b1;
            i_text_byte   = beat.ch;
            i_end_of_text = beat.last;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            @(negedge i_clk);
            burst_left--;
        end
        i_in_valid = 1'b0;
    endtask

    // Wait out every pending result, then the pipeline latency
    task automatic wait_idle();
        while (results_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Receiver: stall in changing patterns, plus one long hold-off on request
    initial begin : receiver
        t_ready_mode mode;
        int          mode_left;
        i_out_ready   = 1'b0;
        hold_off_done = 1'b0;
        mode          = READY_ALWAYS;
        mode_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                READY_ALWAYS: i_out_ready = 1'b1;
                READY_HALF:   i_out_ready = 1'($urandom_range(0, 1));
                READY_SPARSE: i_out_ready = (mode_left % 4 == 0);
                default:      i_out_ready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Abort when neither channel moves a beat for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_text_byte   = '0;
        i_end_of_text = 1'b0;
        target_cfg    = '0;
        burst_left    = 0;
        hold_off_req  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed texts against the target "bat"
        set_target(64'h0000_0000_0074_6162, 64'd0, 64'd3);
        add_string_text("\011x\012PaD\014");   // tab, newline and form feed blanks, case and sound groups
        add_string_text("bat");                  // word closed by end of text
        add_string_text("bats\013\377");         // longer word, high byte, not found
        add_string_text("PAT zz");               // bytes after a match are dropped
        send_beats();
        wait_idle();
        write_reg(REG_TARGET_LEN, 64'd0);        // zero length matches nothing
        add_string_text("bat");
        send_beats();
        wait_idle();

        // Random texts over a range of targets
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_target(random_letter_chars(), random_letter_chars(),
                              64'($urandom_range(1, MAX_WORD)));
                1: set_target(random_letter_chars(), random_letter_chars(),
                              64'(MAX_WORD));
                2: set_target(random_letter_chars(), random_letter_chars(), 64'd1);
                3: set_target(random_letter_chars(), random_letter_chars(), 64'd0);
                4: set_target(random_letter_chars(), random_letter_chars(), 64'd31);
                5: set_target(random_letter_chars(), random_letter_chars(),
                              64'(MAX_WORD + 1));
                6: set_target({64{1'b1}}, {64{1'b1}}, 64'(MAX_WORD));
                7: set_target(64'd0, 64'd0, 64'd8);
                default: set_target({$urandom, $urandom}, {$urandom, $urandom},
                                    64'($urandom_range(1, MAX_WORD)));
            endcase
            // Long receiver hold-off while the sender keeps offering
            if (ph == 1)
                hold_off_req = 1'b1;
            while (text_beats.size() < BEATS_PER_PHASE)
                add_random_text();
            send_beats();
            wait_idle();
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
